// File: design/i2cs_pkg.sv
// Package: payload types, opcodes and bus event codes of the I2C transfer sequencer.
`timescale 1ns / 1ps
package i2cs_pkg;

  typedef struct packed {
    logic [2:0] opcode;
    logic [4:0] index;
    logic [7:0] data_in;
    logic [5:0] msg_size;
    logic       keep_size;
    logic [4:0] event_code;
    logic [7:0] rx_byte;
    logic       scl_level;
    logic       sda_level;
  } in_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       data_valid;
    logic       control_write;
    logic       int_enable;
    logic       clear_flag;
    logic       ack_enable;
    logic       send_start;
    logic       send_stop;
    logic [2:0] status_flags;
    logic [4:0] error_code;
    logic       bus_free;
  } out_t;

  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_MEM  = 2'd1,
    SRC_FF   = 2'd2
  } dsrc_e;

  localparam logic [2:0] OP_LOAD       = 3'd0;
  localparam logic [2:0] OP_START_MST  = 3'd1;
  localparam logic [2:0] OP_START_SLV  = 3'd2;
  localparam logic [2:0] OP_EVENT      = 3'd3;
  localparam logic [2:0] OP_READ       = 3'd4;
  localparam logic [2:0] OP_SLV_READ   = 3'd5;
  localparam logic [2:0] OP_IDLE       = 3'd6;
  localparam logic [2:0] OP_NOP        = 3'd7;

  localparam logic [4:0] EV_BUS_ERROR     = 5'd0;
  localparam logic [4:0] EV_START         = 5'd1;
  localparam logic [4:0] EV_RSTART        = 5'd2;
  localparam logic [4:0] EV_MT_SLA_ACK    = 5'd3;
  localparam logic [4:0] EV_MT_SLA_NACK   = 5'd4;
  localparam logic [4:0] EV_MT_DATA_ACK   = 5'd5;
  localparam logic [4:0] EV_MT_DATA_NACK  = 5'd6;
  localparam logic [4:0] EV_ARB_LOST      = 5'd7;
  localparam logic [4:0] EV_MR_SLA_ACK    = 5'd8;
  localparam logic [4:0] EV_MR_SLA_NACK   = 5'd9;
  localparam logic [4:0] EV_MR_DATA_ACK   = 5'd10;
  localparam logic [4:0] EV_MR_DATA_NACK  = 5'd11;
  localparam logic [4:0] EV_SR_SLA_ACK    = 5'd12;
  localparam logic [4:0] EV_SR_ARB_SLA    = 5'd13;
  localparam logic [4:0] EV_SR_GCALL_ACK  = 5'd14;
  localparam logic [4:0] EV_SR_ARB_GCALL  = 5'd15;
  localparam logic [4:0] EV_SR_DATA_ACK   = 5'd16;
  localparam logic [4:0] EV_SR_DATA_NACK  = 5'd17;
  localparam logic [4:0] EV_SR_GDATA_ACK  = 5'd18;
  localparam logic [4:0] EV_SR_GDATA_NACK = 5'd19;
  localparam logic [4:0] EV_SR_STOP       = 5'd20;
  localparam logic [4:0] EV_ST_SLA_ACK    = 5'd21;
  localparam logic [4:0] EV_ST_ARB_SLA    = 5'd22;
  localparam logic [4:0] EV_ST_DATA_ACK   = 5'd23;
  localparam logic [4:0] EV_ST_DATA_NACK  = 5'd24;
  localparam logic [4:0] EV_ST_LAST_DATA  = 5'd25;
  localparam logic [4:0] EV_NO_STATE      = 5'd26;

endpackage

// File: design/i2cs_buf_ram.sv
// Single-port synchronous byte buffer with registered read data.
`timescale 1ns / 1ps
module i2cs_buf_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

// File: design/i2cs_seq_ctrl.sv
// Sequencer control: decodes items, holds transfer state and the output register.
`timescale 1ns / 1ps
module i2cs_seq_ctrl #(
  parameter int BUFFER_BYTES = 32,
  parameter int IDLE_CHECKS  = 16,
  parameter int AW           = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  i2cs_pkg::in_t         item_i,
  input  logic                  out_pop_i,
  output logic                  out_valid_o,
  output i2cs_pkg::out_t        res_o,
  output i2cs_pkg::dsrc_e       src_o,
  output logic                  mem_en_o,
  output logic                  mem_we_o,
  output logic [AW-1:0]         mem_addr_o,
  output logic [7:0]            mem_wdata_o
);

  localparam int PW = $clog2(BUFFER_BYTES + 1);
  localparam int CW = $clog2(IDLE_CHECKS + 1);
  localparam logic [PW-1:0] BB_P   = PW'(BUFFER_BYTES);
  localparam logic [CW-1:0] IDLE_P = CW'(IDLE_CHECKS);

  logic [PW-1:0] size_q, size_d, ptr_q, ptr_d, p_eff, p_adv;
  logic [4:0]    err_q, err_d;
  logic          done_q, done_d, rxp_q, rxp_d, gc_q, gc_d, busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          outv_q, outv_d;
  i2cs_pkg::out_t  res_q, res_d;
  i2cs_pkg::dsrc_e src_q, src_d;

  logic cw, ie, clr, ea, sta, sto, dv;
  logic idx_ok, p_ok, fetch;

  always_comb begin
    idx_ok = (32'(item_i.index) < BUFFER_BYTES);
    p_eff  = ptr_q;
    if (item_i.event_code == i2cs_pkg::EV_START || item_i.event_code == i2cs_pkg::EV_RSTART ||
        item_i.event_code == i2cs_pkg::EV_ST_SLA_ACK ||
        item_i.event_code == i2cs_pkg::EV_ST_ARB_SLA) begin
      p_eff = '0;
    end
    p_ok  = (p_eff < BB_P);
    p_adv = p_ok ? p_eff + PW'(1) : p_eff;
  end

  always_comb begin
    size_d = size_q;
    ptr_d  = ptr_q;
    err_d  = err_q;
    done_d = done_q;
    rxp_d  = rxp_q;
    gc_d   = gc_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    {cw, ie, clr, ea, sta, sto} = '0;
    dv     = 1'b0;
    fetch  = 1'b0;
    src_d  = i2cs_pkg::SRC_ZERO;
    mem_en_o    = 1'b0;
    mem_we_o    = 1'b0;
    mem_addr_o  = AW'(item_i.index);
    mem_wdata_o = item_i.data_in;

    unique case (item_i.opcode)
      i2cs_pkg::OP_LOAD: begin
        if (idx_ok) begin
          mem_en_o = 1'b1;
          mem_we_o = 1'b1;
        end
      end
      i2cs_pkg::OP_START_MST, i2cs_pkg::OP_START_SLV: begin
        if (!busy_q) begin
          if (!item_i.keep_size) begin
            size_d = (32'(item_i.msg_size) > BUFFER_BYTES) ? BB_P : PW'(item_i.msg_size);
          end
          done_d = 1'b0;
          rxp_d  = 1'b0;
          gc_d   = 1'b0;
          err_d  = i2cs_pkg::EV_NO_STATE;
          cw = 1'b1; ie = 1'b1; clr = 1'b1;
          busy_d = 1'b1;
          ea  = (item_i.opcode == i2cs_pkg::OP_START_MST) ? item_i.keep_size : 1'b1;
          sta = (item_i.opcode == i2cs_pkg::OP_START_MST);
        end
      end
      i2cs_pkg::OP_EVENT: begin
        if (busy_q) begin
          cw = 1'b1;
          ptr_d = p_eff;
          mem_addr_o  = AW'(p_eff);
          mem_wdata_o = item_i.rx_byte;
          unique case (item_i.event_code) inside
            i2cs_pkg::EV_START, i2cs_pkg::EV_RSTART, i2cs_pkg::EV_MT_SLA_ACK,
            i2cs_pkg::EV_MT_DATA_ACK: begin
              if (p_eff < size_q) begin
                fetch = 1'b1;
                {ie, clr} = 2'b11;
              end else begin
                done_d = 1'b1;
                {clr, sto} = 2'b11;
              end
            end
            i2cs_pkg::EV_MT_SLA_NACK, i2cs_pkg::EV_MT_DATA_NACK: begin
              err_d = item_i.event_code;
              {ie, clr, ea, sta} = 4'b1111;
            end
            i2cs_pkg::EV_ARB_LOST: {ie, clr, ea, sta} = 4'b1111;
            i2cs_pkg::EV_MR_SLA_ACK, i2cs_pkg::EV_MR_DATA_ACK: begin
              if (item_i.event_code == i2cs_pkg::EV_MR_DATA_ACK) begin
                mem_en_o = p_ok;
                mem_we_o = p_ok;
                ptr_d    = p_adv;
              end
              {ie, clr} = 2'b11;
              ea = (({1'b0, ptr_d} + (PW + 1)'(1)) < {1'b0, size_q});
            end
            i2cs_pkg::EV_MR_DATA_NACK: begin
              mem_en_o = p_ok;
              mem_we_o = p_ok;
              done_d = 1'b1;
              {clr, ea, sto} = 3'b111;
            end
            i2cs_pkg::EV_MR_SLA_NACK: begin
              err_d = item_i.event_code;
              {ie, clr, ea, sto} = 4'b1111;
            end
            i2cs_pkg::EV_SR_SLA_ACK, i2cs_pkg::EV_SR_ARB_SLA, i2cs_pkg::EV_SR_GCALL_ACK,
            i2cs_pkg::EV_SR_ARB_GCALL: begin
              if (item_i.event_code == i2cs_pkg::EV_SR_GCALL_ACK ||
                  item_i.event_code == i2cs_pkg::EV_SR_ARB_GCALL) begin
                gc_d = 1'b1;
              end
              rxp_d = 1'b1;
              ptr_d = '0;
              {ie, clr, ea} = 3'b111;
            end
            i2cs_pkg::EV_SR_DATA_ACK, i2cs_pkg::EV_SR_GDATA_ACK: begin
              mem_en_o = p_ok;
              mem_we_o = p_ok;
              ptr_d  = p_adv;
              done_d = 1'b1;
              {ie, clr, ea} = 3'b111;
            end
            i2cs_pkg::EV_SR_DATA_NACK, i2cs_pkg::EV_SR_GDATA_NACK: {ie, clr} = 2'b11;
            i2cs_pkg::EV_SR_STOP: cnt_d = IDLE_P;
            i2cs_pkg::EV_ST_SLA_ACK, i2cs_pkg::EV_ST_ARB_SLA, i2cs_pkg::EV_ST_DATA_ACK: begin
              fetch = 1'b1;
              {ie, clr, ea} = 3'b111;
            end
            i2cs_pkg::EV_ST_DATA_NACK: begin
              if (ptr_q == size_q) begin
                done_d = 1'b1;
              end else begin
                err_d = item_i.event_code;
              end
            end
            i2cs_pkg::EV_ST_LAST_DATA: {ie, clr, ea} = 3'b111;
            default: begin
              err_d = item_i.event_code;
              {ie, clr, ea, sto} = 4'b1111;
            end
          endcase
          if (fetch) begin
            dv    = 1'b1;
            ptr_d = p_adv;
            if (p_ok) begin
              mem_en_o = 1'b1;
              src_d    = i2cs_pkg::SRC_MEM;
            end else begin
              src_d    = i2cs_pkg::SRC_FF;
            end
          end
          busy_d = ie;
        end
      end
      i2cs_pkg::OP_READ, i2cs_pkg::OP_SLV_READ: begin
        if (!busy_q && done_q) begin
          if (idx_ok) begin
            mem_en_o = 1'b1;
            dv       = 1'b1;
            src_d    = i2cs_pkg::SRC_MEM;
          end
          if (item_i.opcode == i2cs_pkg::OP_SLV_READ) begin
            rxp_d = 1'b0;
          end
        end
      end
      i2cs_pkg::OP_IDLE: begin
        if (cnt_q != '0) begin
          cnt_d = (item_i.scl_level & item_i.sda_level) ? cnt_q - CW'(1) : IDLE_P;
        end
      end
      default: ;
    endcase

    res_d = '0;
    res_d.data_valid    = dv;
    res_d.control_write = cw;
    res_d.int_enable    = busy_d;
    res_d.clear_flag    = clr;
    res_d.ack_enable    = ea;
    res_d.send_start    = sta;
    res_d.send_stop     = sto;
    res_d.status_flags  = {gc_d, rxp_d, done_d};
    res_d.error_code    = err_d;
    res_d.bus_free      = (cnt_d == '0);

    if (!accept_i) begin
      mem_en_o = 1'b0;
      mem_we_o = 1'b0;
    end
    outv_d = accept_i | (outv_q & ~out_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
      ptr_q  <= '0;
      err_q  <= i2cs_pkg::EV_NO_STATE;
      done_q <= 1'b0;
      rxp_q  <= 1'b0;
      gc_q   <= 1'b0;
      busy_q <= 1'b0;
      cnt_q  <= '0;
      outv_q <= 1'b0;
    end else begin
      outv_q <= outv_d;
      if (accept_i) begin
        size_q <= size_d;
        ptr_q  <= ptr_d;
        err_q  <= err_d;
        done_q <= done_d;
        rxp_q  <= rxp_d;
        gc_q   <= gc_d;
        busy_q <= busy_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      res_q <= res_d;
      src_q <= src_d;
    end
  end

  assign out_valid_o = outv_q;
  assign res_o       = res_q;
  assign src_o       = src_q;

endmodule

// File: design/i2c_master_slave_transfer_sequencer_core.sv
// Top level of the I2C master/slave transfer sequencer.
// The sequencer takes one item per clock cycle unless the result output is stalled, and
// returns its result in the cycle after the item is accepted. The byte buffer is single-port,
// synchronous RAM with registered read data, read or written at most once per item. Transfer
// state sits in flip-flops beside it and updates at acceptance. The result register holds a
// stalled result while the next item is accepted in the same cycle the result is taken. The
// buffer has no reset and no clearing pass: reading an entry never written returns junk.
`timescale 1ns / 1ps
module i2c_master_slave_transfer_sequencer_core #(
  parameter int BUFFER_BYTES = 32,
  parameter int IDLE_CHECKS  = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  i2cs_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output i2cs_pkg::out_t out_data_o
);

  localparam int AW = $clog2(BUFFER_BYTES);

  logic            accept;
  logic            mem_en, mem_we;
  logic [AW-1:0]   mem_addr;
  logic [7:0]      mem_wdata, mem_rdata;
  i2cs_pkg::out_t  res;
  i2cs_pkg::dsrc_e src;

  assign in_ready_o = ~out_valid_o | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  i2cs_seq_ctrl #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .IDLE_CHECKS (IDLE_CHECKS),
    .AW          (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .out_pop_i  (out_ready_i),
    .out_valid_o(out_valid_o),
    .res_o      (res),
    .src_o      (src),
    .mem_en_o   (mem_en),
    .mem_we_o   (mem_we),
    .mem_addr_o (mem_addr),
    .mem_wdata_o(mem_wdata)
  );

  i2cs_buf_ram #(
    .DEPTH(BUFFER_BYTES),
    .AW   (AW)
  ) u_buf (
    .clk_i  (clk_i),
    .en_i   (mem_en),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    out_data_o = res;
    case (src)
      i2cs_pkg::SRC_MEM: out_data_o.data_out = mem_rdata;
      i2cs_pkg::SRC_FF:  out_data_o.data_out = 8'hFF;
      default:           out_data_o.data_out = 8'h00;
    endcase
  end

endmodule

// File: design/i2cs_checker.sv
// Port-level checker for the transfer sequencer, bound to the top level.
`timescale 1ns / 1ps
module i2cs_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input i2cs_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted item produced no result");

  a_ctl_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.control_write |->
      !(out_data_o.clear_flag || out_data_o.ack_enable || out_data_o.send_start ||
        out_data_o.send_stop))
    else $error("control bits set without control write");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.data_valid |-> out_data_o.data_out == 8'h00)
    else $error("data byte without data valid");

endmodule

bind i2c_master_slave_transfer_sequencer_core i2cs_checker u_i2cs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

// File: dv/tb_top.sv
// Testbench for the I2C transfer sequencer: random and directed bus sequences, checked per transfer.
`timescale 1ns / 1ps
module tb_top;

  localparam int BUF_BYTES   = 32;
  localparam int IDLE_CHECKS = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 100;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  i2cs_pkg::in_t  in_data_i   = '0;
  logic           out_ready_i = 1'b0;
  logic           in_ready_o;
  logic           out_valid_o;
  i2cs_pkg::out_t out_data_o;

  i2c_master_slave_transfer_sequencer_core #(
    .BUFFER_BYTES(BUF_BYTES),
    .IDLE_CHECKS (IDLE_CHECKS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  i2cs_pkg::in_t  stim_q[$];
  i2cs_pkg::out_t exp_q[$];
  int   n_in       = 0;
  int   n_total    = 0;
  int   hold_at    = 0;
  int   n_err      = 0;
  int   stall_cnt  = 0;
  int   hold_cnt   = 0;
  bit   hold_done  = 1'b0;

  // shadow of the sequencer state
  logic [7:0]     mem_q[BUF_BYTES];
  int unsigned    size_q = 0;
  int unsigned    ptr_q  = 0;
  int unsigned    idle_q = 0;
  logic [4:0]     err_q  = i2cs_pkg::EV_NO_STATE;
  bit             ok_q   = 1'b0;
  bit             rxp_q  = 1'b0;
  bit             gc_q   = 1'b0;
  bit             busy_q = 1'b0;
  i2cs_pkg::out_t pred;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic set_word(input bit ie, input bit clr, input bit ea, input bit sta,
                          input bit sto);
    busy_q             = ie;
    pred.control_write = 1'b1;
    pred.clear_flag    = clr;
    pred.ack_enable    = ea;
    pred.send_start    = sta;
    pred.send_stop     = sto;
  endtask

  function automatic logic [7:0] tx_byte();
    if (ptr_q < BUF_BYTES) return mem_q[ptr_q];
    return 8'hFF;
  endfunction

  task automatic step_ptr();
    if (ptr_q < BUF_BYTES) ptr_q++;
  endtask

  task automatic keep_rx(input logic [7:0] b);
    if (ptr_q < BUF_BYTES) mem_q[ptr_q] = b;
  endtask

  task automatic predict(input i2cs_pkg::in_t it, output i2cs_pkg::out_t r);
    pred = '0;
    case (it.opcode)
      i2cs_pkg::OP_LOAD: begin
        if (it.index < BUF_BYTES) mem_q[it.index] = it.data_in;
      end
      i2cs_pkg::OP_START_MST, i2cs_pkg::OP_START_SLV: begin
        if (!busy_q) begin
          if (!it.keep_size) begin
            if (it.msg_size > 6'(BUF_BYTES)) size_q = BUF_BYTES;
            else size_q = it.msg_size;
          end
          ok_q  = 1'b0;
          rxp_q = 1'b0;
          gc_q  = 1'b0;
          err_q = i2cs_pkg::EV_NO_STATE;
          if (it.opcode == i2cs_pkg::OP_START_MST) set_word(1, 1, it.keep_size, 1, 0);
          else set_word(1, 1, 1, 0, 0);
        end
      end
      i2cs_pkg::OP_EVENT: begin
        if (busy_q) begin
          case (it.event_code)
            i2cs_pkg::EV_START, i2cs_pkg::EV_RSTART, i2cs_pkg::EV_MT_SLA_ACK,
            i2cs_pkg::EV_MT_DATA_ACK: begin
              if (it.event_code == i2cs_pkg::EV_START ||
                  it.event_code == i2cs_pkg::EV_RSTART) ptr_q = 0;
              if (ptr_q < size_q) begin
                pred.data_out   = tx_byte();
                pred.data_valid = 1'b1;
                step_ptr();
                set_word(1, 1, 0, 0, 0);
              end else begin
                ok_q = 1'b1;
                set_word(0, 1, 0, 0, 1);
              end
            end
            i2cs_pkg::EV_MT_SLA_NACK, i2cs_pkg::EV_MT_DATA_NACK: begin
              err_q = it.event_code;
              set_word(1, 1, 1, 1, 0);
            end
            i2cs_pkg::EV_ARB_LOST: set_word(1, 1, 1, 1, 0);
            i2cs_pkg::EV_MR_SLA_ACK, i2cs_pkg::EV_MR_DATA_ACK: begin
              if (it.event_code == i2cs_pkg::EV_MR_DATA_ACK) begin
                keep_rx(it.rx_byte);
                step_ptr();
              end
              if (ptr_q + 1 < size_q) set_word(1, 1, 1, 0, 0);
              else set_word(1, 1, 0, 0, 0);
            end
            i2cs_pkg::EV_MR_DATA_NACK: begin
              keep_rx(it.rx_byte);
              ok_q = 1'b1;
              set_word(0, 1, 1, 0, 1);
            end
            i2cs_pkg::EV_MR_SLA_NACK: begin
              err_q = it.event_code;
              set_word(1, 1, 1, 0, 1);
            end
            i2cs_pkg::EV_SR_SLA_ACK, i2cs_pkg::EV_SR_ARB_SLA, i2cs_pkg::EV_SR_GCALL_ACK,
            i2cs_pkg::EV_SR_ARB_GCALL: begin
              if (it.event_code == i2cs_pkg::EV_SR_GCALL_ACK ||
                  it.event_code == i2cs_pkg::EV_SR_ARB_GCALL)
                gc_q = 1'b1;
              rxp_q = 1'b1;
              ptr_q = 0;
              set_word(1, 1, 1, 0, 0);
            end
            i2cs_pkg::EV_SR_DATA_ACK, i2cs_pkg::EV_SR_GDATA_ACK: begin
              keep_rx(it.rx_byte);
              step_ptr();
              ok_q = 1'b1;
              set_word(1, 1, 1, 0, 0);
            end
            i2cs_pkg::EV_SR_DATA_NACK, i2cs_pkg::EV_SR_GDATA_NACK: set_word(1, 1, 0, 0, 0);
            i2cs_pkg::EV_SR_STOP: begin
              idle_q = IDLE_CHECKS;
              set_word(0, 0, 0, 0, 0);
            end
            i2cs_pkg::EV_ST_SLA_ACK, i2cs_pkg::EV_ST_ARB_SLA, i2cs_pkg::EV_ST_DATA_ACK: begin
              if (it.event_code != i2cs_pkg::EV_ST_DATA_ACK) ptr_q = 0;
              pred.data_out   = tx_byte();
              pred.data_valid = 1'b1;
              step_ptr();
              set_word(1, 1, 1, 0, 0);
            end
            i2cs_pkg::EV_ST_DATA_NACK: begin
              if (ptr_q == size_q) ok_q = 1'b1;
              else err_q = it.event_code;
              set_word(0, 0, 0, 0, 0);
            end
            i2cs_pkg::EV_ST_LAST_DATA: set_word(1, 1, 1, 0, 0);
            default: begin
              err_q = it.event_code;
              set_word(1, 1, 1, 0, 1);
            end
          endcase
        end
      end
      i2cs_pkg::OP_READ, i2cs_pkg::OP_SLV_READ: begin
        if (!busy_q && ok_q) begin
          if (it.index < BUF_BYTES) begin
            pred.data_out   = mem_q[it.index];
            pred.data_valid = 1'b1;
          end
          if (it.opcode == i2cs_pkg::OP_SLV_READ) rxp_q = 1'b0;
        end
      end
      i2cs_pkg::OP_IDLE: begin
        if (idle_q > 0) begin
          if (it.scl_level && it.sda_level) idle_q--;
          else idle_q = IDLE_CHECKS;
        end
      end
      default: ;
    endcase
    pred.int_enable   = busy_q;
    pred.status_flags = {gc_q, rxp_q, ok_q};
    pred.error_code   = err_q;
    pred.bus_free     = (idle_q == 0);
    r = pred;
  endtask

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    n_err++;
  endtask

  task automatic cmp(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  function automatic int phase_now();
    if (n_total == 0) return 2;
    return (n_in * 3) / n_total;
  endfunction

  function automatic int tx_idle_pct();
    case (phase_now())
      0: return 15;
      1: return 85;
      default: return 0;
    endcase
  endfunction

  function automatic int rx_idle_pct();
    case (phase_now())
      0: return 85;
      1: return 15;
      default: return 0;
    endcase
  endfunction

  // driver and predictor
  always @(posedge clk_i) begin : drv
    i2cs_pkg::out_t res;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict(in_data_i, res);
        exp_q.push_back(res);
        n_in <= n_in + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (stim_q.size() != 0 && $urandom_range(99) >= tx_idle_pct()) begin
          in_data_i  <= stim_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure, with one long hold-off late in the run
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt    <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else if (!hold_done && n_in >= hold_at) begin
      hold_done   <= 1'b1;
      hold_cnt    <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct());
    end
  end

  // monitor
  always @(posedge clk_i) begin : mon
    i2cs_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_q.size() == 0) begin
        report("result transfer with nothing expected");
      end else begin
        want = exp_q.pop_front();
        cmp("data_out", out_data_o.data_out, want.data_out);
        cmp("data_valid", 8'(out_data_o.data_valid), 8'(want.data_valid));
        cmp("control_write", 8'(out_data_o.control_write), 8'(want.control_write));
        cmp("int_enable", 8'(out_data_o.int_enable), 8'(want.int_enable));
        cmp("clear_flag", 8'(out_data_o.clear_flag), 8'(want.clear_flag));
        cmp("ack_enable", 8'(out_data_o.ack_enable), 8'(want.ack_enable));
        cmp("send_start", 8'(out_data_o.send_start), 8'(want.send_start));
        cmp("send_stop", 8'(out_data_o.send_stop), 8'(want.send_stop));
        cmp("status_flags", 8'(out_data_o.status_flags), 8'(want.status_flags));
        cmp("error_code", 8'(out_data_o.error_code), 8'(want.error_code));
        cmp("bus_free", 8'(out_data_o.bus_free), 8'(want.bus_free));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  // stimulus builders
  function automatic i2cs_pkg::in_t noise();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(i2cs_pkg::in_t)-1:0];
  endfunction

  function automatic i2cs_pkg::in_t op_item(input logic [2:0] op);
    i2cs_pkg::in_t it;
    it        = noise();
    it.opcode = op;
    return it;
  endfunction

  task automatic load(input logic [4:0] idx, input logic [7:0] b);
    i2cs_pkg::in_t it;
    it         = op_item(i2cs_pkg::OP_LOAD);
    it.index   = idx;
    it.data_in = b;
    stim_q.push_back(it);
  endtask

  task automatic start(input logic [2:0] op, input int unsigned sz, input bit keep);
    i2cs_pkg::in_t it;
    it           = op_item(op);
    it.msg_size  = 6'(sz);
    it.keep_size = keep;
    stim_q.push_back(it);
  endtask

  task automatic bus_ev(input logic [4:0] ev);
    i2cs_pkg::in_t it;
    it            = op_item(i2cs_pkg::OP_EVENT);
    it.event_code = ev;
    stim_q.push_back(it);
  endtask

  task automatic rd(input logic [2:0] op, input logic [4:0] idx);
    i2cs_pkg::in_t it;
    it       = op_item(op);
    it.index = idx;
    stim_q.push_back(it);
  endtask

  task automatic idle_smp(input bit scl, input bit sda);
    i2cs_pkg::in_t it;
    it           = op_item(i2cs_pkg::OP_IDLE);
    it.scl_level = scl;
    it.sda_level = sda;
    stim_q.push_back(it);
  endtask

  function automatic int unsigned sz_pick();
    if ($urandom_range(9) == 0) return $urandom_range(9, 63);
    return $urandom_range(0, 8);
  endfunction

  function automatic bit keep_pick();
    return ($urandom_range(7) == 0);
  endfunction

  // occasional out-of-sequence bus status
  task automatic glitch();
    if ($urandom_range(19) == 0) bus_ev(5'($urandom_range(0, 31)));
  endtask

  task automatic tail_reads();
    repeat ($urandom_range(0, 3)) begin
      rd($urandom_range(1) ? i2cs_pkg::OP_SLV_READ : i2cs_pkg::OP_READ,
         5'($urandom_range(0, 31)));
    end
  endtask

  task automatic idle_burst();
    repeat ($urandom_range(2, 20)) begin
      if ($urandom_range(9) == 0) idle_smp(1'($urandom_range(1)), 1'($urandom_range(1)));
      else idle_smp(1'b1, 1'b1);
    end
  endtask

  task automatic seq_mst_wr();
    int unsigned sz;
    sz = sz_pick();
    start(i2cs_pkg::OP_START_MST, sz, keep_pick());
    bus_ev(i2cs_pkg::EV_START);
    bus_ev(i2cs_pkg::EV_MT_SLA_ACK);
    repeat (sz + $urandom_range(0, 1)) begin
      glitch();
      bus_ev(i2cs_pkg::EV_MT_DATA_ACK);
    end
    bus_ev(i2cs_pkg::EV_SR_STOP);
    tail_reads();
  endtask

  task automatic seq_mst_rd();
    int unsigned sz;
    sz = sz_pick();
    start(i2cs_pkg::OP_START_MST, sz, keep_pick());
    bus_ev($urandom_range(1) ? i2cs_pkg::EV_START : i2cs_pkg::EV_RSTART);
    bus_ev(i2cs_pkg::EV_MR_SLA_ACK);
    repeat (sz > 2 ? sz - 2 : 0) begin
      glitch();
      bus_ev(i2cs_pkg::EV_MR_DATA_ACK);
    end
    bus_ev(i2cs_pkg::EV_MR_DATA_NACK);
    tail_reads();
  endtask

  task automatic seq_slv_rx();
    int unsigned sz;
    int unsigned n;
    sz = sz_pick();
    n  = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 8);
    start(i2cs_pkg::OP_START_SLV, sz, keep_pick());
    bus_ev(5'(i2cs_pkg::EV_SR_SLA_ACK + $urandom_range(0, 3)));
    repeat (n) begin
      glitch();
      bus_ev(5'(i2cs_pkg::EV_SR_DATA_ACK + $urandom_range(0, 3)));
    end
    bus_ev(i2cs_pkg::EV_SR_STOP);
    tail_reads();
    idle_burst();
  endtask

  task automatic seq_slv_tx();
    int unsigned sz;
    int unsigned n;
    sz = sz_pick();
    n  = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : sz + $urandom_range(0, 1);
    start(i2cs_pkg::OP_START_SLV, sz, keep_pick());
    bus_ev($urandom_range(1) ? i2cs_pkg::EV_ST_SLA_ACK : i2cs_pkg::EV_ST_ARB_SLA);
    repeat (n > 0 ? n - 1 : 0) begin
      glitch();
      bus_ev(i2cs_pkg::EV_ST_DATA_ACK);
    end
    if ($urandom_range(3) == 0) bus_ev(i2cs_pkg::EV_ST_LAST_DATA);
    bus_ev(i2cs_pkg::EV_ST_DATA_NACK);
    tail_reads();
  endtask

  initial begin
    // every buffer entry is written before anything can read it
    for (int i = 0; i < BUF_BYTES; i++) load(5'(i), 8'($urandom_range(0, 255)));

    rd(i2cs_pkg::OP_READ, 5'd0);
    idle_smp(1'b1, 1'b1);
    bus_ev(i2cs_pkg::EV_START);
    start(i2cs_pkg::OP_START_MST, 63, 1'b0);
    start(i2cs_pkg::OP_START_SLV, 4, 1'b0);
    bus_ev(i2cs_pkg::EV_START);
    bus_ev(i2cs_pkg::EV_MT_SLA_NACK);
    bus_ev(i2cs_pkg::EV_ARB_LOST);
    bus_ev(i2cs_pkg::EV_BUS_ERROR);
    bus_ev(5'd31);
    bus_ev(i2cs_pkg::EV_NO_STATE);
    bus_ev(i2cs_pkg::EV_MR_SLA_NACK);
    bus_ev(i2cs_pkg::EV_SR_STOP);
    idle_smp(1'b0, 1'b1);
    idle_smp(1'b1, 1'b1);
    stim_q.push_back(op_item(i2cs_pkg::OP_NOP));
    start(i2cs_pkg::OP_START_SLV, 0, 1'b0);
    bus_ev(i2cs_pkg::EV_SR_GCALL_ACK);
    bus_ev(i2cs_pkg::EV_SR_GDATA_ACK);
    bus_ev(i2cs_pkg::EV_SR_GDATA_NACK);
    bus_ev(i2cs_pkg::EV_SR_STOP);
    rd(i2cs_pkg::OP_SLV_READ, 5'd0);
    start(i2cs_pkg::OP_START_SLV, 1, 1'b0);
    bus_ev(i2cs_pkg::EV_ST_ARB_SLA);
    bus_ev(i2cs_pkg::EV_ST_LAST_DATA);
    bus_ev(i2cs_pkg::EV_ST_DATA_NACK);

    while (stim_q.size() < 480) begin
      case ($urandom_range(9))
        0, 1: seq_mst_wr();
        2, 3: seq_mst_rd();
        4, 5: seq_slv_rx();
        6, 7: seq_slv_tx();
        8: repeat ($urandom_range(1, 4)) stim_q.push_back(noise());
        default: begin
          tail_reads();
          idle_burst();
        end
      endcase
    end
    n_total = stim_q.size();
    hold_at = (n_total * 5) / 6;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || in_valid_i || exp_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (n_err == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: i2c_master_slave_transfer_sequencer_core.f
design/i2cs_pkg.sv
design/i2cs_buf_ram.sv
design/i2cs_seq_ctrl.sv
design/i2c_master_slave_transfer_sequencer_core.sv
design/i2cs_checker.sv
dv/tb_top.sv
